// File: design/fixed_slot_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed slot pool allocator assertion macros
// Shared macros for the port checker of the pool allocator.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define FSPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fspa checker: property failed");

// Check that holds in the cycle after its condition.
`define FSPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fspa checker: property failed");

`endif

// File: design/fspa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator package
// Field widths, register indexes, status codes and request/response types.
// ----------------------------------------------------------------------------
package fspa_pkg;

    // Fixed field widths.
    localparam int ADDR_W_MAX = 64;
    localparam int OBJ_W      = 16;
    localparam int SIZE_W     = OBJ_W + 1;
    localparam int SC_W       = 9;
    localparam int CNT_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Default parameter values.
    localparam int DEF_MAX_SLOTS        = 256;
    localparam int DEF_ADDRESS_WIDTH    = 64;
    localparam int DEF_SLOT_ALIGN_BYTES = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd2;

    // Configuration reset values.
    localparam logic [OBJ_W-1:0] RST_OBJECT_SIZE = 16'd8;
    localparam logic [SC_W-1:0]  RST_SLOT_COUNT  = 9'd256;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

    typedef struct packed {
        logic                  req_type;
        logic [ADDR_W_MAX-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W_MAX-1:0] slot_address;
        logic [CNT_W-1:0]      free_slots;
        logic [CNT_W-1:0]      active_slots;
    } t_rsp;

endpackage

// File: design/fspa_stack_mem.sv
// ----------------------------------------------------------------------------
// Freed slot stack memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fspa_stack_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fspa_divider.sv
// ----------------------------------------------------------------------------
// Slot index divider
// Restoring division, one quotient bit per cycle, for offsets known to be
// below (2^QW) times the divisor.
// ----------------------------------------------------------------------------
module fspa_divider #(
    parameter int QW = 8,
    parameter int DW = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [QW+DW-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_done,
    output logic [QW-1:0]    o_quot,
    output logic [DW-1:0]    o_rem
);

    localparam int NW   = QW + DW;
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_dsh;
    logic [QW-1:0]   r_quot;
    logic            w_fits;
    logic [NW-1:0]   w_diff;

    // Trial subtraction of the shifted divisor.
    assign w_fits = (r_rem >= r_dsh);
    assign w_diff = r_rem - r_dsh;

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Remainder, shifted divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsh  <= NW'(i_divisor) << (QW - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= w_diff;
            end
            r_quot <= (r_quot << 1) | QW'(w_fits);
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DW-1:0];

endmodule

// File: design/fixed_slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// Hands out equal-sized slots from a pool at a configured base address and
// takes them back onto a stack of freed slot indexes held in a memory.
// ----------------------------------------------------------------------------
// Sequence: an allocate goes through S_ALLOC, S_MUL and S_DONE, or S_ALLOC and S_DONE
//   when the pool is empty; a free goes through S_CHK, S_LIM, S_RANGE, S_DIV (the
//   bit-serial divider) and S_DONE, or skips S_DIV for an address outside the pool.
// Requests: one at a time; the next can be taken once the result is registered, while
//   that result waits at the output. Reset: synchronous, active low; clears the state,
//   stack depth, untouched counter and response valid, and loads the config reset values.
module fixed_slot_pool_allocator import fspa_pkg::*; #(
    parameter int MAX_SLOTS        = DEF_MAX_SLOTS,
    parameter int ADDRESS_WIDTH    = DEF_ADDRESS_WIDTH,
    parameter int SLOT_ALIGN_BYTES = DEF_SLOT_ALIGN_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_stall,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IW          = $clog2(MAX_SLOTS);
    localparam int CW          = $clog2(MAX_SLOTS + 1);
    localparam int EW          = (CW > SC_W) ? CW : SC_W;
    localparam int PW          = IW + SIZE_W;
    localparam int LW          = CW + SIZE_W;
    localparam int RECIP_SHIFT = SIZE_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int SPW         = SIZE_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + SLOT_ALIGN_BYTES - 1) / SLOT_ALIGN_BYTES);
    localparam logic [CW-1:0]         MAX_CNT   = CW'(MAX_SLOTS);
    localparam logic [EW-1:0]         MAX_EXT   = EW'(MAX_SLOTS);
    localparam logic [ADDR_W_MAX-1:0] ADDR_MASK =
        {ADDR_W_MAX{1'b1}} >> (ADDR_W_MAX - ADDRESS_WIDTH);
    localparam logic [OBJ_W-1:0]      ALIGN_OBJ = OBJ_W'(SLOT_ALIGN_BYTES);
    localparam logic [SIZE_W-1:0]     ALIGN_SZ  = SIZE_W'(SLOT_ALIGN_BYTES);
    localparam logic [SIZE_W-1:0]     ALIGN_PAD = SIZE_W'(SLOT_ALIGN_BYTES - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_LIM   = 3'd4;
    localparam logic [2:0] S_RANGE = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Configuration registers and derived sizes.
    logic [ADDR_W_MAX-1:0] r_base;
    logic [OBJ_W-1:0]      r_object_size;
    logic [SC_W-1:0]       r_slot_count;
    logic [SIZE_W-1:0]     w_sz_up;
    logic [SPW-1:0]        w_sz_prod;
    logic [SIZE_W-1:0]     r_sz_quot;
    logic [SIZE_W-1:0]     r_eff_size;
    logic [EW-1:0]         w_sc_ext;
    logic [CW-1:0]         w_eff_cnt;
    logic [ADDR_W_MAX-1:0] w_base;

    // Sequencer and request state.
    logic [2:0]            r_state, n_state;
    t_req                  r_req;
    logic [CW-1:0]         r_depth, n_depth;
    logic [CW-1:0]         r_next, n_next;
    logic [CW-1:0]         w_depth_m1;
    logic [IW-1:0]         r_idx, n_idx;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [PW-1:0]         r_prod;
    logic                  r_lt;
    logic [ADDR_W_MAX-1:0] r_off;
    logic [LW-1:0]         r_limit;
    logic [ADDR_W_MAX-1:0] w_p;
    logic [ADDR_W_MAX-1:0] w_alloc_addr;

    // Memory and divider connections.
    logic                  w_mem_we;
    logic                  w_mem_re;
    logic [IW-1:0]         w_mem_rdata;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [IW-1:0]         w_div_quot;
    logic [SIZE_W-1:0]     w_div_rem;

    // Handshake and counts.
    logic                  w_req_accept;
    logic                  w_rsp_free;
    logic                  w_rsp_load;
    logic                  r_rsp_valid;
    t_rsp                  r_rsp;
    t_rsp                  w_rsp;
    logic [CW-1:0]         w_untouched;
    logic [CW:0]           w_free_sum;
    logic [CW-1:0]         w_free_cnt;

    // Slot size: at least the alignment, rounded up to a multiple of it.
    // The division by the alignment is a multiply by its reciprocal.
    assign w_sz_up   = SIZE_W'((r_object_size < ALIGN_OBJ) ? ALIGN_OBJ : r_object_size)
                     + ALIGN_PAD;
    assign w_sz_prod = SPW'(w_sz_up) * SPW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_sz_quot  <= SIZE_W'(w_sz_prod >> RECIP_SHIFT);
        r_eff_size <= SIZE_W'(r_sz_quot * ALIGN_SZ);
    end

    // Slot count: zero counts as one, and it saturates at the pool capacity.
    assign w_sc_ext  = EW'(r_slot_count);
    assign w_eff_cnt = (r_slot_count == '0)  ? CW'(1) :
                       (w_sc_ext > MAX_EXT)  ? MAX_CNT : CW'(w_sc_ext);
    assign w_base    = r_base & ADDR_MASK;

    // Handshake.
    assign o_req_stall  = (r_state != S_IDLE);
    assign w_req_accept = i_req_valid && !o_req_stall;
    assign w_rsp_free   = !r_rsp_valid || !i_rsp_stall;
    assign w_depth_m1   = r_depth - CW'(1);
    assign w_p          = r_req.free_address & ADDR_MASK;

    // Sequencer: pop or hand out on allocate, check and push on free.
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_next      = r_next;
        n_idx       = r_idx;
        n_status    = r_status;
        w_mem_re    = 1'b0;
        w_mem_we    = 1'b0;
        w_div_start = 1'b0;
        w_rsp_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_accept) begin
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_ALLOC) begin
                        w_mem_re = (r_depth != '0);
                        n_state  = S_ALLOC;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_ALLOC: begin
                if (r_depth != '0) begin
                    n_idx   = w_mem_rdata;
                    n_depth = w_depth_m1;
                    n_state = S_MUL;
                end else if (r_next < w_eff_cnt) begin
                    n_idx   = r_next[IW-1:0];
                    n_next  = r_next + CW'(1);
                    n_state = S_MUL;
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end
            end
            S_MUL: begin
                n_state = S_DONE;
            end
            S_CHK: begin
                n_state = S_LIM;
            end
            S_LIM: begin
                n_state = S_RANGE;
            end
            S_RANGE: begin
                if (r_lt || (r_off >= ADDR_W_MAX'(r_limit))) begin
                    n_status = ST_BAD_ADDR;
                    n_state  = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    if (w_div_rem != '0) begin
                        n_status = ST_BAD_ADDR;
                    end else if (r_depth < MAX_CNT) begin
                        w_mem_we = 1'b1;
                        n_depth  = r_depth + CW'(1);
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_rsp_free) begin
                    w_rsp_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_depth       <= '0;
            r_next        <= '0;
            r_rsp_valid   <= 1'b0;
            r_base        <= '0;
            r_object_size <= RST_OBJECT_SIZE;
            r_slot_count  <= RST_SLOT_COUNT;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_next  <= n_next;
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_ADDRESS: r_base        <= i_cfg_wdata;
                    CFG_OBJECT_SIZE:  r_object_size <= i_cfg_wdata[OBJ_W-1:0];
                    CFG_SLOT_COUNT:   r_slot_count  <= i_cfg_wdata[SC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Request payload and intermediate results.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (w_req_accept) begin
            r_req <= i_req;
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_idx) * PW'(r_eff_size);
        end
        if (r_state == S_CHK) begin
            r_lt  <= (w_p < w_base);
            r_off <= w_p - w_base;
        end
        if (r_state == S_LIM) begin
            r_limit <= LW'(w_eff_cnt) * LW'(r_eff_size);
        end
        if (w_rsp_load) begin
            r_rsp <= w_rsp;
        end
    end

    // Result: slot address and the free and active counts after the request.
    assign w_alloc_addr = (w_base + ADDR_W_MAX'(r_prod)) & ADDR_MASK;
    assign w_untouched  = (r_next < w_eff_cnt) ? (w_eff_cnt - r_next) : '0;
    assign w_free_sum   = (CW + 1)'(r_depth) + (CW + 1)'(w_untouched);
    assign w_free_cnt   = (w_free_sum > (CW + 1)'(w_eff_cnt)) ? w_eff_cnt
                                                               : w_free_sum[CW-1:0];

    always_comb begin
        w_rsp.status       = r_status;
        w_rsp.slot_address = ((r_req.req_type == REQ_ALLOC) && (r_status == ST_OK))
                             ? w_alloc_addr : '0;
        w_rsp.free_slots   = CNT_W'(w_free_cnt);
        w_rsp.active_slots = CNT_W'(w_eff_cnt - w_free_cnt);
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Stack of freed slot indexes.
    fspa_stack_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (IW)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_depth[IW-1:0]),
        .i_wdata (w_div_quot),
        .i_re    (w_mem_re),
        .i_raddr (w_depth_m1[IW-1:0]),
        .o_rdata (w_mem_rdata)
    );

    // Offset to slot index.
    fspa_divider #(
        .QW (IW),
        .DW (SIZE_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_off[PW-1:0]),
        .i_divisor  (r_eff_size),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

endmodule

// File: design/fspa_checker.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator port checker
// Watches the top-level ports and checks handshake and result consistency.
// ----------------------------------------------------------------------------
`include "fixed_slot_pool_allocator_defines.svh"

module fspa_checker import fspa_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  o_req_stall,
    input logic                  o_rsp_valid,
    input logic                  i_rsp_stall,
    input t_rsp                  o_rsp
);

    // A stalled result stays valid and unchanged.
    `FSPA_ASSERT_NEXT(a_rsp_hold, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp))

    // The block works on one request at a time.
    `FSPA_ASSERT_NEXT(a_busy_after_req, i_req_valid && !o_req_stall, o_req_stall)

    // A failed request never carries a slot address.
    `FSPA_ASSERT_NOW(a_no_addr_on_fail, o_rsp_valid && (o_rsp.status != ST_OK), o_rsp.slot_address == '0)

    // An empty pool has no free slot left.
    `FSPA_ASSERT_NOW(a_empty_none_free, o_rsp_valid && (o_rsp.status == ST_EMPTY), o_rsp.free_slots == '0)

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Fixed slot pool allocator testbench
// Drives allocate and free requests under random sender bursts and receiver
// stalls, predicts each response from a local copy of the slot pool, and
// compares every response field with the prediction in request order.
// ----------------------------------------------------------------------------
module tb_top;
    import fspa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RANDOM_REQS = 1500;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    // Block ports.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_stall;
    t_req                  i_req       = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_stall = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BASE_ADDRESS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Local copy of the registers and the pool state.
    logic [63:0]    cfg_base      = 64'd0;
    logic [15:0]    cfg_obj_size  = RST_OBJECT_SIZE;
    logic [8:0]     cfg_slot_cnt  = RST_SLOT_COUNT;
    logic [7:0]     freed_idx [DEF_MAX_SLOTS];
    int unsigned    freed_cnt     = 0;
    int unsigned    untouched_next = 0;

    // Request queue, predicted responses and bookkeeping.
    t_req           pending_req_q [$];
    t_rsp           pool_rsp_q [$];
    int unsigned    n_queued      = 0;
    int unsigned    n_accepted    = 0;
    int unsigned    err_cnt       = 0;
    int unsigned    cycle_cnt     = 0;
    bit             req_taken     = 1'b0;

    // Sender and receiver idling state.
    int unsigned    burst_left    = 1;
    int unsigned    idle_gap      = 0;
    t_stall_mode    stall_mode    = STALL_NONE;
    int unsigned    stall_left    = 0;
    int unsigned    stall_run     = 0;
    bit             stall_hi      = 1'b0;

    fixed_slot_pool_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Slot size: at least eight bytes, rounded up to a multiple of eight.
    function automatic logic [63:0] slot_bytes();
        logic [63:0] s;
        s = 64'(cfg_obj_size);
        if (s < 64'd8) begin
            s = 64'd8;
        end
        return ((s + 64'd7) >> 3) << 3;
    endfunction

    // Slots in use: zero counts as one, large values saturate.
    function automatic int unsigned slots_in_use();
        int unsigned n;
        n = cfg_slot_cnt;
        if (n == 0) begin
            n = 1;
        end
        if (n > DEF_MAX_SLOTS) begin
            n = DEF_MAX_SLOTS;
        end
        return n;
    endfunction

    // Apply one request to the local pool and return the response it causes.
    function automatic t_rsp pool_step(t_req rq);
        logic [63:0] sz;
        logic [63:0] off;
        int unsigned n;
        int unsigned idx;
        int unsigned untouched;
        int unsigned fr;
        bit          got;
        t_rsp        r;
        sz = slot_bytes();
        n = slots_in_use();
        r = '0;
        r.status = ST_OK;
        idx = 0;
        if (rq.req_type == REQ_ALLOC) begin
            // Most recently freed slot first, then the next untouched one.
            got = 1'b1;
            if (freed_cnt > 0) begin
                freed_cnt--;
                idx = freed_idx[freed_cnt];
            end else if (untouched_next < n) begin
                idx = untouched_next;
                untouched_next++;
            end else begin
                got = 1'b0;
            end
            if (got) begin
                r.slot_address = cfg_base + 64'(idx) * sz;
            end else begin
                r.status = ST_EMPTY;
            end
        end else begin
            // A free must land inside the pool on a slot boundary.
            if (rq.free_address < cfg_base) begin
                r.status = ST_BAD_ADDR;
            end else begin
                off = rq.free_address - cfg_base;
                if (off >= 64'(n) * sz || off % sz != 64'd0) begin
                    r.status = ST_BAD_ADDR;
                end else if (freed_cnt < DEF_MAX_SLOTS) begin
                    freed_idx[freed_cnt] = 8'(off / sz);
                    freed_cnt++;
                end
            end
        end
        untouched = (untouched_next < n) ? n - untouched_next : 0;
        fr = freed_cnt + untouched;
        if (fr > n) begin
            fr = n;
        end
        r.free_slots = 9'(fr);
        r.active_slots = 9'(n - fr);
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_cnt < 100) begin
            $display("cycle %0d: %s: got %0h, predicted %0h", cycle_cnt, what, got, want);
        end
        err_cnt++;
    endtask

    // Request side monitor, response checker and cycle limit.
    always @(posedge i_clk) begin
        t_rsp want;
        cycle_cnt++;
        req_taken = i_rst_n && i_req_valid && !o_req_stall;
        if (req_taken) begin
            pool_rsp_q.push_back(pool_step(i_req));
            n_accepted++;
        end
        if (i_rst_n && o_rsp_valid === 1'b1 && !i_rsp_stall) begin
            if (pool_rsp_q.size() == 0) begin
                report_mismatch("response with no request waiting", o_rsp.slot_address, 0);
            end else begin
                want = pool_rsp_q.pop_front();
                if (o_rsp.status !== want.status) begin
                    report_mismatch("status", o_rsp.status, want.status);
                end
                if (o_rsp.slot_address !== want.slot_address) begin
                    report_mismatch("slot_address", o_rsp.slot_address, want.slot_address);
                end
                if (o_rsp.free_slots !== want.free_slots) begin
                    report_mismatch("free_slots", o_rsp.free_slots, want.free_slots);
                end
                if (o_rsp.active_slots !== want.active_slots) begin
                    report_mismatch("active_slots", o_rsp.active_slots, want.active_slots);
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("fixed_slot_pool_allocator: mismatch");
            $finish;
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_req_valid || req_taken)) begin
            if (idle_gap > 0) begin
                idle_gap--;
                i_req_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
                i_req <= pending_req_q.pop_front();
                i_req_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(24, 1);
                    idle_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Response stall pattern: a random mode, chosen anew when its countdown runs out.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(3));
            stall_left = $urandom_range(300, 40);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_rsp_stall <= ($urandom_range(3) == 0);
            end
            STALL_HEAVY: begin
                i_rsp_stall <= ($urandom_range(9) < 7);
            end
            default: begin
                if (stall_run == 0) begin
                    stall_hi = !stall_hi;
                    stall_run = $urandom_range(20, 1);
                end else begin
                    stall_run--;
                end
                i_rsp_stall <= stall_hi;
            end
        endcase
    end

    // Queue one request for the driver.
    task automatic queue_pool_req(input logic rtype, input logic [63:0] addr);
        t_req rq;
        rq.req_type = rtype;
        rq.free_address = addr;
        pending_req_q.push_back(rq);
        n_queued++;
    endtask

    // Write one register and mirror it in the local copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_BASE_ADDRESS: cfg_base = data;
            CFG_OBJECT_SIZE:  cfg_obj_size = data[15:0];
            CFG_SLOT_COUNT:   cfg_slot_cnt = data[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every response has come back.
    task automatic wait_pool_idle();
        wait (n_accepted == n_queued);
        wait (pool_rsp_q.size() == 0);
        repeat (16) @(posedge i_clk);
    endtask

    // One random request: mostly allocates and frees of real slots, some noise.
    task automatic queue_random_req(input int unsigned alloc_pct);
        logic [63:0] sz;
        logic [63:0] addr;
        int unsigned n;
        int unsigned pick;
        sz = slot_bytes();
        n = slots_in_use();
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            queue_pool_req(REQ_ALLOC, {$urandom, $urandom});
        end else if (pick < 90) begin
            addr = cfg_base + 64'($urandom_range(n - 1)) * sz;
            queue_pool_req(REQ_FREE, addr);
        end else begin
            case ($urandom_range(3))
                0: addr = {$urandom, $urandom};
                1: addr = cfg_base + 64'($urandom_range(n - 1)) * sz
                          + 64'($urandom_range(int'(sz) - 1, 1));
                2: addr = cfg_base + 64'(n) * sz;
                default: addr = cfg_base - 64'd1;
            endcase
            queue_pool_req(REQ_FREE, addr);
        end
    endtask

    // Random register setting, extremes included.
    task automatic write_random_config(input bit all_regs);
        logic [63:0] data;
        int unsigned pick;
        if (all_regs || $urandom_range(1)) begin
            pick = $urandom_range(9);
            if (pick < 2) begin
                data = 64'd0;
            end else if (pick < 3) begin
                data = 64'hFFFF_FFFF_FFFF_FFFF;
            end else if (pick < 5) begin
                data = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(16'hFFFF));
            end else begin
                data = {$urandom, $urandom};
            end
            write_reg(CFG_BASE_ADDRESS, data);
        end
        if (all_regs || $urandom_range(1)) begin
            data = {$urandom, $urandom};
            pick = $urandom_range(9);
            if (pick == 0) begin
                data[15:0] = 16'd0;
            end else if (pick == 1) begin
                data[15:0] = 16'hFFFF;
            end else if (pick < 4) begin
                data[15:0] = 16'($urandom_range(8, 1));
            end else if (pick < 9) begin
                data[15:0] = 16'($urandom_range(64, 1));
            end else begin
                data[15:0] = 16'($urandom);
            end
            write_reg(CFG_OBJECT_SIZE, data);
        end
        if (all_regs || $urandom_range(1)) begin
            data = {$urandom, $urandom};
            pick = $urandom_range(19);
            if (pick < 3) begin
                data[8:0] = 9'd0;
            end else if (pick < 5) begin
                data[8:0] = 9'd256;
            end else if (pick < 7) begin
                data[8:0] = 9'($urandom_range(511, 257));
            end else if (pick < 13) begin
                data[8:0] = 9'($urandom_range(8, 1));
            end else begin
                data[8:0] = 9'($urandom_range(255, 1));
            end
            write_reg(CFG_SLOT_COUNT, data);
        end
    endtask

    // Stimulus sequence and end of run.
    initial begin
        int unsigned rand_reqs;
        int unsigned phase;
        int unsigned len;
        logic [63:0] data;
        rand_reqs = 0;
        phase = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: fresh slots, address zero, bad addresses, double frees.
        queue_pool_req(REQ_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_pool_req(REQ_ALLOC, 64'd0);
        queue_pool_req(REQ_FREE, 64'd0);
        queue_pool_req(REQ_FREE, 64'd4);
        queue_pool_req(REQ_FREE, 64'd2048);
        queue_pool_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_pool_req(REQ_ALLOC, 64'd0);
        repeat (3) queue_pool_req(REQ_FREE, 64'd8);
        repeat (3) queue_pool_req(REQ_ALLOC, 64'd0);
        wait_pool_idle();

        // Size zero, count zero, base at the top of the address space.
        write_reg(CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(CFG_OBJECT_SIZE, 64'd0);
        write_reg(CFG_SLOT_COUNT, 64'd0);
        queue_pool_req(REQ_ALLOC, 64'd0);
        queue_pool_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFF0);
        queue_pool_req(REQ_ALLOC, 64'd0);
        queue_pool_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFF8);
        wait_pool_idle();

        // Four slots: the last two wrap past the top and cannot be freed.
        write_reg(CFG_SLOT_COUNT, 64'd4);
        repeat (3) queue_pool_req(REQ_ALLOC, 64'd0);
        queue_pool_req(REQ_FREE, 64'd0);
        queue_pool_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFF8);
        queue_pool_req(REQ_ALLOC, 64'd0);
        queue_pool_req(REQ_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_pool_idle();

        // Random phases; the sender pauses for all responses between phases.
        while (rand_reqs < RANDOM_REQS) begin
            if (phase == 0) begin
                write_reg(CFG_BASE_ADDRESS, {$urandom, $urandom});
                data = {$urandom, $urandom};
                data[15:0] = 16'hFFFF;
                write_reg(CFG_OBJECT_SIZE, data);
                data[8:0] = 9'h1FF;
                write_reg(CFG_SLOT_COUNT, data);
            end else if (phase == 2) begin
                // Fill the freed stack past its depth with double frees.
                write_random_config(1'b0);
                write_reg(CFG_SLOT_COUNT, 64'd256);
                repeat (DEF_MAX_SLOTS + 4) begin
                    queue_pool_req(REQ_FREE,
                                   cfg_base + 64'($urandom_range(255)) * slot_bytes());
                end
                rand_reqs += DEF_MAX_SLOTS + 4;
            end else if ($urandom_range(9) < 7) begin
                write_random_config($urandom_range(3) == 0);
            end
            len = $urandom_range(150, 20);
            rand_reqs += len;
            begin
                int unsigned alloc_pct;
                alloc_pct = $urandom_range(70, 25);
                repeat (len) queue_random_req(alloc_pct);
            end
            wait_pool_idle();
            phase++;
        end

        // Drain and report.
        wait (n_accepted == n_queued);
        wait (pool_rsp_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (pool_rsp_q.size() != 0) begin
            report_mismatch("responses never returned", pool_rsp_q.size(), 0);
        end
        if (err_cnt == 0) begin
            $display("fixed_slot_pool_allocator: match");
        end else begin
            $display("fixed_slot_pool_allocator: mismatch");
        end
        $finish;
    end

endmodule
